/* rtl/pcvlfs_pkg.sv */
package pcvlfs_pkg;

    localparam int unsigned MANT_FRAC = 30;
    localparam int unsigned LIN_W     = 42;
    localparam int unsigned EXP_CELLS = 11;
    localparam int unsigned LOG_CELLS = 12;
    localparam int unsigned NORM_TOP  = 30;
    localparam int unsigned LIN_ONE   = 24;
    localparam int unsigned RANGE_MAX = 8;

    localparam logic [LIN_W-1:0] LIN_FLOOR = LIN_W'(16384);

    // 2^40 / 261.6256, rounded
    localparam logic [31:0] INV_C4 =
        32'(((64'd1 << 40) * 64'd10000 + 64'd1308128) / 64'd2616256);

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_KNOB   = 2'd0;
    localparam cfg_index_t CFG_RANGE  = 2'd1;
    localparam cfg_index_t CFG_AMOUNT = 2'd2;
    localparam cfg_index_t CFG_ENABLE = 2'd3;

    typedef struct packed {
        logic [31:0]        m;
        logic [10:0]        frac;
        logic signed [4:0]  ip;
        logic signed [15:0] modv;
    } exp_word_t;

    typedef struct packed {
        logic [30:0] m;
        logic [11:0] bits;
        logic [5:0]  n;
    } log_word_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        v   = v_in;
        res = 64'd0;
        bt  = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
        begin
            if (v >= res + bt)
            begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
            begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // 2^(2^b/2048) in q1.30, by repeated square roots from 2.0
    function automatic logic [30:0] exp_coef(input int unsigned b);
        logic [63:0] c;
        c = 64'd2 << MANT_FRAC;
        for (int i = 10; i >= 0; i--)
        begin
            if (i >= int'(b))
            begin
                c = isqrt64(c << MANT_FRAC);
            end
        end
        return c[30:0];
    endfunction

    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                      input int unsigned s);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return v[63] ? -signed'(mag) : signed'(mag);
    endfunction

endpackage

/* rtl/pcvlfs_exp_cell.sv */
module pcvlfs_exp_cell #(
    parameter int unsigned BIT_IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pcvlfs_pkg::exp_word_t in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pcvlfs_pkg::exp_word_t out_word
);
    import pcvlfs_pkg::*;

    localparam logic [30:0] COEF = exp_coef(BIT_IDX);

    logic      valid_reg;
    exp_word_t word_reg;
    exp_word_t word_next;
    logic [62:0] prod;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        prod      = 63'(in_word.m) * 63'(COEF) + (63'd1 << 29);
        word_next = in_word;
        if (in_word.frac[BIT_IDX])
        begin
            word_next.m = prod[61:30];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

/* rtl/pcvlfs_log_cell.sv */
module pcvlfs_log_cell #(
    parameter int unsigned BIT_IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pcvlfs_pkg::log_word_t in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pcvlfs_pkg::log_word_t out_word
);
    import pcvlfs_pkg::*;

    logic      valid_reg;
    log_word_t word_reg;
    log_word_t word_next;
    logic [61:0] sq;
    logic [31:0] t;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        sq        = 62'(in_word.m) * 62'(in_word.m);
        t         = sq[61:30];
        word_next = in_word;
        word_next.bits[BIT_IDX] = t[31];
        word_next.m = t[31] ? t[31:1] : t[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

endmodule

/* rtl/pitch_cv_linear_frequency_shift_unit.sv */
// Linear frequency shifter for 1V/octave pitch: each word is taken to the linear domain,
// offset by the knob shift (and the modulation term when enabled), floored at -10 V and
// taken back with log2. One word enters per cycle unless out_ready stalls the pipeline,
// which is 11 exp2 multiply cells, four mixing/normalizing stages, 12 log2 squaring cells
// and the output register. Configuration must be written while no word is in flight.
module pitch_cv_linear_frequency_shift_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] pitch_volts,
    input  logic signed [15:0] mod_volts,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] shifted_pitch,
    input  logic               cfg_wr_en,
    input  pcvlfs_pkg::cfg_index_t cfg_index,
    input  logic [15:0]        cfg_data
);
    import pcvlfs_pkg::*;

    logic signed [15:0] knob_reg;
    logic [3:0]         range_reg;
    logic [15:0]        amount_reg;
    logic               enable_reg;

    logic signed [48:0] kp_reg;
    logic signed [33:0] shift_reg;
    logic [31:0]        a2_reg;
    logic [31:0]        a4_reg;
    logic [3:0]         range_eff;
    logic signed [63:0] kv;
    logic signed [63:0] kr;
    logic [63:0]        a4_prod;

    logic               exp_v   [0:EXP_CELLS];
    logic               exp_rdy [0:EXP_CELLS];
    exp_word_t          exp_w   [0:EXP_CELLS];

    logic               l_valid_reg;
    logic [LIN_W-1:0]   lin_reg;
    logic signed [48:0] mprod_reg;
    logic               l_rdy;
    logic signed [6:0]  sh;
    logic [LIN_W-1:0]   lin_next;
    logic signed [48:0] mprod_next;

    logic               s_valid_reg;
    logic [LIN_W-1:0]   x_reg;
    logic               s_rdy;
    logic signed [63:0] mr;
    logic signed [43:0] sum;
    logic [LIN_W-1:0]   x_next;

    logic               z_valid_reg;
    logic [LIN_W-1:0]   zx_reg;
    logic [5:0]         zn_reg;
    logic               z_rdy;
    logic [5:0]         zn_next;

    logic               n_valid_reg;
    log_word_t          nw_reg;
    logic               n_rdy;
    log_word_t          nw_next;

    logic               lg_v   [0:LOG_CELLS];
    logic               lg_rdy [0:LOG_CELLS];
    log_word_t          lg_w   [0:LOG_CELLS];

    logic               o_valid_reg;
    logic signed [15:0] o_reg;
    logic               o_rdy;
    logic signed [6:0]  e;
    logic signed [18:0] r;
    logic signed [18:0] r1;
    logic signed [15:0] o_next;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knob_reg   <= '0;
            range_reg  <= 4'd4;
            amount_reg <= '0;
            enable_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_KNOB:   knob_reg   <= signed'(cfg_data);
                CFG_RANGE:  range_reg  <= cfg_data[3:0];
                CFG_AMOUNT: amount_reg <= cfg_data;
                CFG_ENABLE: enable_reg <= cfg_data[0];
                default:    knob_reg   <= knob_reg;
            endcase
        end
    end

    // derived shift (kp_reg, then shift_reg) and modulation gain (a2_reg, then a4_reg)
    always_comb
    begin
        range_eff = (range_reg > 4'(RANGE_MAX)) ? 4'(RANGE_MAX) : range_reg;
        kv        = {{15{kp_reg[48]}}, kp_reg} <<< range_eff;
        kr        = round_shift(kv, 24);
        a4_prod   = 64'(a2_reg) * 64'(a2_reg) + (64'd1 << 31);
    end

    always_ff @(posedge clk)
    begin
        kp_reg    <= 49'(knob_reg) * signed'({17'd0, INV_C4});
        shift_reg <= kr[33:0];
        a2_reg    <= 32'(amount_reg) * 32'(amount_reg);
        a4_reg    <= a4_prod[63:32];
    end

    // exp2 row
    assign exp_v[0]      = in_valid;
    assign in_ready      = exp_rdy[0];
    assign exp_w[0].m    = 32'd1 << MANT_FRAC;
    assign exp_w[0].frac = pitch_volts[10:0];
    assign exp_w[0].ip   = pitch_volts[15:11];
    assign exp_w[0].modv = mod_volts;

    for (genvar g = 0; g < EXP_CELLS; g++)
    begin : g_exp
        pcvlfs_exp_cell #(.BIT_IDX(g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (exp_v[g]),
            .in_ready  (exp_rdy[g]),
            .in_word   (exp_w[g]),
            .out_valid (exp_v[g+1]),
            .out_ready (exp_rdy[g+1]),
            .out_word  (exp_w[g+1])
        );
    end

    // linear scale and modulation product
    assign l_rdy                = !l_valid_reg || s_rdy;
    assign exp_rdy[EXP_CELLS]   = l_rdy;

    always_comb
    begin
        sh = 7'sd6 - 7'(exp_w[EXP_CELLS].ip);
        if (sh[6])
        begin
            lin_next = LIN_W'(exp_w[EXP_CELLS].m) << 7'(-sh);
        end
        else
        begin
            lin_next = LIN_W'(exp_w[EXP_CELLS].m) >> sh;
        end
        mprod_next = 49'(exp_w[EXP_CELLS].modv) * signed'({17'd0, a4_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_valid_reg <= 1'b0;
        end
        else if (l_rdy)
        begin
            l_valid_reg <= exp_v[EXP_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (l_rdy && exp_v[EXP_CELLS])
        begin
            lin_reg   <= lin_next;
            mprod_reg <= mprod_next;
        end
    end

    // sum and floor
    assign s_rdy = !s_valid_reg || z_rdy;

    always_comb
    begin
        mr  = round_shift({{15{mprod_reg[48]}}, mprod_reg}, 19);
        sum = signed'({2'b00, lin_reg}) + 44'(shift_reg);
        if (enable_reg)
        begin
            sum = sum + 44'(signed'(mr[29:0]));
        end
        if (sum < signed'({2'b00, LIN_FLOOR}))
        begin
            x_next = LIN_FLOOR;
        end
        else
        begin
            x_next = sum[LIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (s_rdy)
        begin
            s_valid_reg <= l_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_rdy && l_valid_reg)
        begin
            x_reg <= x_next;
        end
    end

    // leading one
    assign z_rdy = !z_valid_reg || n_rdy;

    always_comb
    begin
        zn_next = '0;
        for (int i = 0; i < LIN_W; i++)
        begin
            if (x_reg[i])
            begin
                zn_next = 6'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_valid_reg <= 1'b0;
        end
        else if (z_rdy)
        begin
            z_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (z_rdy && s_valid_reg)
        begin
            zx_reg <= x_reg;
            zn_reg <= zn_next;
        end
    end

    // normalize to q1.30
    assign n_rdy = !n_valid_reg || lg_rdy[0];

    always_comb
    begin
        nw_next.bits = '0;
        nw_next.n    = zn_reg;
        if (zn_reg > 6'(NORM_TOP))
        begin
            nw_next.m = 31'(zx_reg >> (zn_reg - 6'(NORM_TOP)));
        end
        else
        begin
            nw_next.m = 31'(zx_reg << (6'(NORM_TOP) - zn_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
        end
        else if (n_rdy)
        begin
            n_valid_reg <= z_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_rdy && z_valid_reg)
        begin
            nw_reg <= nw_next;
        end
    end

    // log2 row, msb first
    assign lg_v[0] = n_valid_reg;
    assign lg_w[0] = nw_reg;

    for (genvar g = 0; g < LOG_CELLS; g++)
    begin : g_log
        pcvlfs_log_cell #(.BIT_IDX(LOG_CELLS - 1 - g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (lg_v[g]),
            .in_ready  (lg_rdy[g]),
            .in_word   (lg_w[g]),
            .out_valid (lg_v[g+1]),
            .out_ready (lg_rdy[g+1]),
            .out_word  (lg_w[g+1])
        );
    end

    // to q.11 and saturate
    assign o_rdy              = !o_valid_reg || out_ready;
    assign lg_rdy[LOG_CELLS]  = o_rdy;

    always_comb
    begin
        e  = signed'({1'b0, lg_w[LOG_CELLS].n}) - 7'sd24;
        r  = signed'({e, lg_w[LOG_CELLS].bits});
        r1 = (r + 19'sd1) >>> 1;
        if (r1 > 19'sd32767)
        begin
            o_next = 16'sd32767;
        end
        else if (r1 < -19'sd32768)
        begin
            o_next = -16'sd32768;
        end
        else
        begin
            o_next = r1[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (o_rdy)
        begin
            o_valid_reg <= lg_v[LOG_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_rdy && lg_v[LOG_CELLS])
        begin
            o_reg <= o_next;
        end
    end

    assign out_valid     = o_valid_reg;
    assign shifted_pitch = o_reg;

    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg |-> (x_reg >= LIN_FLOOR))
        else $error("linear sum below floor");

    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        n_valid_reg |-> nw_reg.m[30])
        else $error("mantissa not normalized");

    a_log_norm: assert property (@(posedge clk) disable iff (!rst_n)
        lg_v[LOG_CELLS] |-> lg_w[LOG_CELLS].m[30])
        else $error("log mantissa lost normalization");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        exp_v[EXP_CELLS] |-> (exp_w[EXP_CELLS].m >= (32'd1 << MANT_FRAC)))
        else $error("exp mantissa below one");

endmodule

/* dv/pitch_cv_linear_frequency_shift_unit_tb.sv */
module pitch_cv_linear_frequency_shift_unit_tb;
    import pcvlfs_pkg::*;

    typedef struct {
        logic signed [15:0] pitch;
        logic signed [15:0] modv;
    } pitch_word_t;

    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT  = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] pitch_volts = '0;
    logic signed [15:0] mod_volts = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] shifted_pitch;
    logic cfg_wr_en = 1'b0;
    cfg_index_t cfg_index = CFG_KNOB;
    logic [15:0] cfg_data = '0;

    pitch_word_t pending_words[$];
    logic signed [15:0] expected_pitch[$];
    logic [63:0] root_tab[11];

    logic signed [15:0] knob_hz = 16'sd0;
    logic [3:0] range_sel = 4'd4;
    logic [15:0] amount = 16'd0;
    logic enable = 1'b0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned hold_cnt = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;

    pitch_cv_linear_frequency_shift_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pitch_volts(pitch_volts), .mod_volts(mod_volts),
        .out_valid(out_valid), .out_ready(out_ready),
        .shifted_pitch(shifted_pitch),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        v   = v_in;
        res = 0;
        bt  = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
        begin
            if (v >= res + bt)
            begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
            begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] div_round(input logic signed [63:0] v,
                                                    input int unsigned s);
        logic [63:0] mag;
        mag = v < 0 ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return v < 0 ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [15:0] shifted_pitch_of(input pitch_word_t w);
        logic [63:0] m;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        logic [63:0] a2;
        logic [63:0] a4;
        int ip;
        int s;
        int n;
        int unsigned rng;
        m  = 64'd1 << 30;
        for (int b = 0; b < 11; b++)
        begin
            if (w.pitch[b])
            begin
                m = (m * root_tab[b] + (64'd1 << 29)) >> 30;
            end
        end
        ip = int'($signed(w.pitch[15:11]));
        s  = 6 - ip;
        if (s > 0)
            m = m >> s;
        else
            m = m << (-s);
        sum = $signed(m);
        rng = range_sel > 8 ? 8 : range_sel;
        sum = sum + div_round(64'(knob_hz) * (64'sd1 <<< rng) * $signed(64'(INV_C4)), 24);
        if (enable)
        begin
            a2  = 64'(amount) * 64'(amount);
            a4  = (a2 * a2 + (64'd1 << 31)) >> 32;
            sum = sum + div_round(64'(w.modv) * $signed(a4), 19);
        end
        if (sum < 64'sd16384)
            sum = 64'sd16384;
        n = 0;
        for (int k = 63; k > 0; k--)
        begin
            if (sum[k] && n == 0)
                n = k;
        end
        m = n > 30 ? 64'(sum) >> (n - 30) : 64'(sum) << (30 - n);
        r = 64'(n - 24) * 4096;
        for (int k = 11; k >= 0; k--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                r = r + (64'sd1 <<< k);
                m = m >> 1;
            end
        end
        r = (r + 1) >>> 1;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    task automatic report_mismatch(input logic signed [15:0] got, input logic signed [15:0] want);
        $display("mismatch shifted_pitch: got %0d expected %0d", got, want);
        errors++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_KNOB:   knob_hz = data;
            CFG_RANGE:  range_sel = data[3:0];
            CFG_AMOUNT: amount = data;
            CFG_ENABLE: enable = data[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] k, input logic [15:0] rg,
                              input logic [15:0] a, input logic [15:0] e);
        write_reg(CFG_KNOB, k);
        write_reg(CFG_RANGE, rg);
        write_reg(CFG_AMOUNT, a);
        write_reg(CFG_ENABLE, e);
    endtask

    task automatic push_word(input logic signed [15:0] p, input logic signed [15:0] mv);
        pitch_word_t w;
        w.pitch = p;
        w.modv  = mv;
        pending_words.push_back(w);
    endtask

    task automatic wait_drain();
        while (pending_words.size() != 0 || in_valid || expected_pitch.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_volts();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(0, 40960)) - 20480);
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_pitch.push_back(shifted_pitch_of('{pitch_volts, mod_volts}));
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid    <= 1'b1;
                    pitch_volts <= pending_words[0].pitch;
                    mod_volts   <= pending_words[0].modv;
                    pending_words.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_cnt  <= 300;
            out_ready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pitch.size() == 0)
            begin
                $display("unexpected word: shifted_pitch %0d", shifted_pitch);
                errors++;
            end
            else
            begin
                if (shifted_pitch !== expected_pitch[0])
                    report_mismatch(shifted_pitch, expected_pitch[0]);
                expected_pitch.pop_front();
            end
        end
    end

    initial
    begin
        for (int b = 0; b < 11; b++)
            root_tab[b] = 0;
        begin
            logic [63:0] c;
            c = 64'd2 << 30;
            for (int b = 10; b >= 0; b--)
            begin
                c = int_sqrt(c << 30);
                root_tab[b] = c;
            end
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration first, then extremes
        push_word(-16'sd20480, 16'sd0);
        push_word(16'sd20480, 16'sd0);
        push_word(16'sd0, 16'sd0);
        push_word(16'sh7FFF, 16'sh8000);
        push_word(16'sh8000, 16'sh7FFF);
        push_word(16'sh07FF, 16'sd0);
        push_word(-16'sd1, 16'sd0);
        wait_drain();
        set_config(16'h7FFF, 16'd8, 16'hFFFF, 16'd1);
        push_word(16'sd0, 16'sd20480);
        push_word(16'sd0, -16'sd20480);
        push_word(16'sd20480, 16'sd20480);
        push_word(-16'sd20480, -16'sd20480);
        wait_drain();
        set_config(16'h8000, 16'd15, 16'hFFFF, 16'd0);
        push_word(16'sd0, 16'sd20480);
        push_word(16'sd20480, -16'sd20480);
        push_word(-16'sd20480, 16'sd0);
        wait_drain();
        set_config(16'h8000, 16'd9, 16'hFFFF, 16'd1);
        push_word(16'sd0, 16'sd20480);
        push_word(16'sd20480, -16'sd20480);
        push_word(16'sd4096, -16'sd20480);
        wait_drain();
        set_config(16'h0100, 16'd0, 16'h8000, 16'd1);
        push_word(16'sd0, 16'sd0);
        push_word(16'sh0555, 16'sh2AAA);
        push_word(16'sh2AAA, 16'shD555);
        wait_drain();

        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            if (ph % 3 == 0)
                set_config($urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                           $urandom_range(0, 1) ? 16'd8 : 16'd0,
                           $urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom));
            else
                set_config(16'($urandom), 16'($urandom_range(0, 15)),
                           16'($urandom), 16'($urandom));
            if (ph == 4)
                hold_req = 1'b1;
            for (int i = 0; i < 130; i++)
                push_word(rand_volts(), rand_volts());
            wait_drain();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/pcvlfs_pkg.sv
rtl/pcvlfs_exp_cell.sv
rtl/pcvlfs_log_cell.sv
rtl/pitch_cv_linear_frequency_shift_unit.sv
dv/pitch_cv_linear_frequency_shift_unit_tb.sv
